// ----- hdl/lrpp_pkg.sv -----
package lrpp_pkg;

    localparam int PACKET_BYTES = 1206;
    localparam int BLOCK_COUNT  = 12;
    localparam int BLOCK_BYTES  = 100;
    localparam int CHANNELS     = 16;

    localparam int DATA_BYTES   = BLOCK_COUNT * BLOCK_BYTES;
    localparam int HEADER_BYTES = 4;
    localparam int POS_W        = $clog2(PACKET_BYTES + 1);
    localparam int BLK_W        = 4;
    localparam int OFF_W        = $clog2(BLOCK_BYTES);
    localparam int CHAN_W       = $clog2(CHANNELS);

    localparam logic [7:0] FLAG_FIRST  = 8'hFF;
    localparam logic [7:0] FLAG_SECOND = 8'hEE;

    localparam logic [OFF_W-1:0] OFF_FLAG0   = OFF_W'(0);
    localparam logic [OFF_W-1:0] OFF_FLAG1   = OFF_W'(1);
    localparam logic [OFF_W-1:0] OFF_AZ_LOW  = OFF_W'(2);
    localparam logic [OFF_W-1:0] OFF_AZ_HIGH = OFF_W'(3);
    localparam logic [OFF_W-1:0] OFF_LAST    = OFF_W'(BLOCK_BYTES - 1);

    typedef enum logic [1:0] {
        PART_DIST_LOW  = 2'd0,
        PART_DIST_HIGH = 2'd1,
        PART_SPARE     = 2'd2
    } t_part;

    typedef enum logic {
        KIND_POINT  = 1'b0,
        KIND_STATUS = 1'b1
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        t_kind              kind;
        logic [15:0]        azimuth;
        logic [15:0]        distance;
        logic signed [11:0] elevation;
        logic [3:0]         channel;
        logic               sequence_res;
        logic [3:0]         block_index;
        logic               packet_ok;
        logic               last_result;
    } t_out_word;

    function automatic logic signed [11:0] elevation_of(input logic [CHAN_W-1:0] chan);
        logic signed [11:0] elev;
        unique case (chan)
            4'd0:    elev = -12'sd1500;
            4'd1:    elev = 12'sd100;
            4'd2:    elev = -12'sd1300;
            4'd3:    elev = 12'sd300;
            4'd4:    elev = -12'sd1100;
            4'd5:    elev = 12'sd500;
            4'd6:    elev = -12'sd900;
            4'd7:    elev = 12'sd700;
            4'd8:    elev = -12'sd700;
            4'd9:    elev = 12'sd900;
            4'd10:   elev = -12'sd500;
            4'd11:   elev = 12'sd1100;
            4'd12:   elev = -12'sd300;
            4'd13:   elev = 12'sd1300;
            4'd14:   elev = -12'sd100;
            default: elev = 12'sd1500;
        endcase
        return elev;
    endfunction

endpackage

// ----- hdl/lidar_return_packet_parser.sv -----
// Parses a lidar data packet that arrives one payload word per cycle. Each of
// the twelve 100-byte blocks that opens with 0xFF 0xEE yields one point word
// for every return with a nonzero distance, sent as soon as the return's
// second distance byte is taken; the packet's last word adds an end-of-packet
// status word that flags packets shorter than 1206 bytes. Bytes past 1206 are
// ignored. A three-entry result queue decouples the two sides, so the block
// takes one word per clock while the queue holds at most one result, and
// stalls while it holds two or more, as after a last word that also completes
// a point or while the output side is not ready.
module lidar_return_packet_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lrpp_pkg::t_in_word i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lrpp_pkg::t_out_word o_out
);
    import lrpp_pkg::*;

    logic [POS_W-1:0]  r_pos, n_pos;
    logic [BLK_W-1:0]  r_blk, n_blk;
    logic [OFF_W-1:0]  r_off, n_off;
    t_part             r_part, n_part;
    logic [CHAN_W-1:0] r_chan, n_chan;
    logic              r_seq, n_seq;
    logic              r_flag_ok, n_flag_ok;
    logic              r_first_seen, n_first_seen;
    logic [15:0]       r_azimuth, n_azimuth;
    logic [7:0]        r_az_low, n_az_low;
    logic [7:0]        r_dist_low, n_dist_low;

    t_out_word         r_q [3];
    t_out_word         n_q [3];
    logic [1:0]        r_count, n_count;

    logic              accept;
    logic              pop;
    logic              in_data;
    logic [15:0]       ret_dist;
    logic              point_valid;
    t_out_word         point_word;
    t_out_word         status_word;
    t_out_word         item0;
    logic [1:0]        num_push;
    logic [1:0]        base;

    assign o_in_ready  = (r_count <= 2'd1);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = (r_count != 2'd0);
    assign o_out       = r_q[0];
    assign pop         = o_out_valid && i_out_ready;

    assign in_data     = (r_pos < POS_W'(DATA_BYTES));
    assign ret_dist    = {i_in.data_byte, r_dist_low};
    assign point_valid = in_data && (r_off >= OFF_W'(HEADER_BYTES))
                         && (r_part == PART_DIST_HIGH) && r_flag_ok && (ret_dist != 16'd0);

    always_comb begin
        point_word              = '0;
        point_word.kind         = KIND_POINT;
        point_word.azimuth      = r_azimuth;
        point_word.distance     = ret_dist;
        point_word.elevation    = elevation_of(r_chan);
        point_word.channel      = r_chan;
        point_word.sequence_res = r_seq;
        point_word.block_index  = r_blk;
        point_word.packet_ok    = 1'b0;
        point_word.last_result  = !i_in.last_byte;

        status_word             = '0;
        status_word.kind        = KIND_STATUS;
        status_word.packet_ok   = (r_pos >= POS_W'(PACKET_BYTES - 1));
        status_word.last_result = 1'b1;

        item0    = point_valid ? point_word : status_word;
        num_push = {1'b0, point_valid} + {1'b0, i_in.last_byte};
    end

    always_comb begin
        n_pos        = r_pos;
        n_blk        = r_blk;
        n_off        = r_off;
        n_part       = r_part;
        n_chan       = r_chan;
        n_seq        = r_seq;
        n_flag_ok    = r_flag_ok;
        n_first_seen = r_first_seen;
        n_azimuth    = r_azimuth;
        n_az_low     = r_az_low;
        n_dist_low   = r_dist_low;

        if (accept) begin
            if (in_data) begin
                priority if (r_off == OFF_FLAG0) begin
                    n_first_seen = (i_in.data_byte == FLAG_FIRST);
                    n_flag_ok    = 1'b0;
                end else if (r_off == OFF_FLAG1) begin
                    n_flag_ok = r_first_seen && (i_in.data_byte == FLAG_SECOND);
                end else if (r_off == OFF_AZ_LOW) begin
                    n_az_low = i_in.data_byte;
                end else if (r_off == OFF_AZ_HIGH) begin
                    n_azimuth = {i_in.data_byte, r_az_low};
                end else begin
                    if (r_part == PART_DIST_LOW) begin
                        n_dist_low = i_in.data_byte;
                    end
                end

                if (r_off == OFF_LAST) begin
                    n_off  = '0;
                    n_blk  = r_blk + BLK_W'(1);
                    n_part = PART_DIST_LOW;
                    n_chan = '0;
                    n_seq  = 1'b0;
                end else begin
                    n_off = r_off + OFF_W'(1);
                    if (r_off >= OFF_W'(HEADER_BYTES)) begin
                        unique case (r_part)
                            PART_DIST_LOW:  n_part = PART_DIST_HIGH;
                            PART_DIST_HIGH: n_part = PART_SPARE;
                            default: begin
                                n_part = PART_DIST_LOW;
                                n_chan = r_chan + CHAN_W'(1);
                                if (r_chan == CHAN_W'(CHANNELS - 1)) begin
                                    n_seq = 1'b1;
                                end
                            end
                        endcase
                    end
                end
            end

            if (r_pos < POS_W'(PACKET_BYTES)) begin
                n_pos = r_pos + POS_W'(1);
            end

            if (i_in.last_byte) begin
                n_pos        = '0;
                n_blk        = '0;
                n_off        = '0;
                n_part       = PART_DIST_LOW;
                n_chan       = '0;
                n_seq        = 1'b0;
                n_flag_ok    = 1'b0;
                n_first_seen = 1'b0;
                n_azimuth    = '0;
                n_az_low     = '0;
                n_dist_low   = '0;
            end
        end
    end

    always_comb begin
        n_q  = r_q;
        base = r_count - {1'b0, pop};
        if (pop) begin
            n_q[0] = r_q[1];
            n_q[1] = r_q[2];
        end
        if (accept) begin
            if (num_push != 2'd0) begin
                n_q[base] = item0;
            end
            if (num_push == 2'd2) begin
                n_q[base + 2'd1] = status_word;
            end
        end
        n_count = base + (accept ? num_push : 2'd0);
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
        if (!i_rst_n) begin
            r_count      <= '0;
            r_pos        <= '0;
            r_blk        <= '0;
            r_off        <= '0;
            r_part       <= PART_DIST_LOW;
            r_chan       <= '0;
            r_seq        <= 1'b0;
            r_flag_ok    <= 1'b0;
            r_first_seen <= 1'b0;
            r_azimuth    <= '0;
            r_az_low     <= '0;
            r_dist_low   <= '0;
        end else begin
            r_count      <= n_count;
            r_pos        <= n_pos;
            r_blk        <= n_blk;
            r_off        <= n_off;
            r_part       <= n_part;
            r_chan       <= n_chan;
            r_seq        <= n_seq;
            r_flag_ok    <= n_flag_ok;
            r_first_seen <= n_first_seen;
            r_azimuth    <= n_azimuth;
            r_az_low     <= n_az_low;
            r_dist_low   <= n_dist_low;
        end
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3 || !o_in_ready)
        else $error("result queue full while input is ready");

    a_pos_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(PACKET_BYTES))
        else $error("byte position passed the packet length");

    a_point_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.kind == KIND_POINT |->
            !o_out.packet_ok && o_out.distance != 16'd0
            && o_out.block_index < BLK_W'(BLOCK_COUNT))
        else $error("malformed point word");

    a_status_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.kind == KIND_STATUS |->
            o_out.last_result && o_out.distance == 16'd0 && o_out.azimuth == 16'd0)
        else $error("malformed status word");

    a_two_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && point_valid && i_in.last_byte |=> r_count >= 2'd2)
        else $error("point and status not both queued");
`endif

endmodule
